### rtl/adts_pkg.sv
// ----------------------------------------------------------------------------
// adts_pkg: shared types and constants for the ADTS PCM frame deframer
// Phase and status codes, the result record and the default queue depth.
// ----------------------------------------------------------------------------
package adts_pkg;

	localparam int unsigned HDR_BYTES     = 7;
	localparam int unsigned FIFO_DEPTH    = 8;
	localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
	localparam logic [3:0]  SYNC_NIBBLE   = 4'hF;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_SKIP    = 2'd2,
		PH_ERROR   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SYNC  = 3'd1,
		ST_SHORT = 3'd2,
		ST_ODD   = 3'd3,
		ST_TRUNC = 3'd4,
		ST_EMPTY = 3'd5
	} status_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               is_status;
		logic [2:0]         status;
		logic               last;
	} res_t;

	// Results caused by one byte, in delivery order.
	typedef struct packed {
		logic [1:0] count;
		res_t       first;
		res_t       second;
	} res_pair_t;

endpackage

### rtl/adts_byte_if.sv
// ----------------------------------------------------------------------------
// adts_byte_if: byte stream channel
// Valid/ready channel carrying one buffer byte and its end-of-buffer flag.
// ----------------------------------------------------------------------------
interface adts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/adts_result_if.sv
// ----------------------------------------------------------------------------
// adts_result_if: result channel
// Valid/ready channel carrying one sample or one end-of-buffer status.
// ----------------------------------------------------------------------------
interface adts_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               is_status;
	logic [2:0]         status;
	logic               last;

	modport source (output valid, output sample, output is_status, output status,
		output last, input ready);
	modport sink   (input valid, input sample, input is_status, input status,
		input last, output ready);
endinterface

### rtl/adts_parse.sv
// ----------------------------------------------------------------------------
// adts_parse: header and payload parser
// Updates the frame state for one registered byte and produces up to two
// results: a completed sample and, on the final byte, the buffer status.
// ----------------------------------------------------------------------------
module adts_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output adts_pkg::res_pair_t results
);

	adts_pkg::phase_t phase_q, phase_n;
	logic [2:0]  hcount_q, hcount_n;
	logic [7:0]  hdr0_q, hdr0_n;
	logic        sync_q, sync_n;
	logic [7:0]  hdr_q [3];
	logic [7:0]  hdr_n [3];
	logic [12:0] left_q, left_n;
	logic [7:0]  low_q, low_n;
	logic        lowpend_q, lowpend_n;
	logic [2:0]  err_q, err_n;
	logic        any_q, any_n;

	logic [12:0] frame_len;
	logic [12:0] pay_len;
	logic [1:0]  hdr_idx;
	logic        emit_sample;
	adts_pkg::res_t sample_res;
	adts_pkg::res_t status_res;
	adts_pkg::status_t fin_status;

	assign frame_len = {hdr_q[0][1:0], hdr_q[1], hdr_q[2][7:5]};
	assign pay_len   = frame_len - 13'(adts_pkg::HDR_BYTES);
	assign hdr_idx   = 2'(hcount_q - 3'd3);

	// Next state for one byte
	always_comb begin
		phase_n     = phase_q;
		hcount_n    = hcount_q;
		hdr0_n      = hdr0_q;
		sync_n      = sync_q;
		hdr_n       = hdr_q;
		left_n      = left_q;
		low_n       = low_q;
		lowpend_n   = lowpend_q;
		err_n       = err_q;
		any_n       = any_q;
		emit_sample = 1'b0;
		case (phase_q)
			adts_pkg::PH_HEADER: begin
				if (hcount_q == 3'd0) begin
					hdr0_n = data_byte;
				end
				if (hcount_q == 3'd1) begin
					sync_n = (hdr0_q == adts_pkg::SYNC_BYTE) &&
						(data_byte[7:4] == adts_pkg::SYNC_NIBBLE);
				end
				if (hcount_q >= 3'd3 && hcount_q <= 3'd5) begin
					hdr_n[hdr_idx] = data_byte;
				end
				hcount_n = hcount_q + 3'd1;
				if (hcount_q == 3'(adts_pkg::HDR_BYTES - 1)) begin
					hcount_n = 3'd0;
					if (!sync_q) begin
						err_n   = adts_pkg::ST_SYNC;
						phase_n = adts_pkg::PH_ERROR;
					end else if (frame_len < 13'(adts_pkg::HDR_BYTES)) begin
						err_n   = adts_pkg::ST_SHORT;
						phase_n = adts_pkg::PH_ERROR;
					end else if (pay_len != 13'd0) begin
						left_n    = pay_len;
						lowpend_n = 1'b0;
						phase_n   = pay_len[0] ? adts_pkg::PH_SKIP : adts_pkg::PH_PAYLOAD;
					end
				end
			end
			adts_pkg::PH_PAYLOAD: begin
				if (!lowpend_q) begin
					low_n     = data_byte;
					lowpend_n = 1'b1;
				end else begin
					emit_sample = 1'b1;
					lowpend_n   = 1'b0;
					any_n       = 1'b1;
				end
				left_n = left_q - 13'd1;
				if (left_n == 13'd0) begin
					phase_n  = adts_pkg::PH_HEADER;
					hcount_n = 3'd0;
				end
			end
			adts_pkg::PH_SKIP: begin
				left_n = left_q - 13'd1;
				if (left_n == 13'd0) begin
					err_n   = adts_pkg::ST_ODD;
					phase_n = adts_pkg::PH_ERROR;
				end
			end
			default: begin
			end
		endcase
	end

	// Buffer status from the state after this byte
	always_comb begin
		if (err_n != 3'd0) begin
			fin_status = adts_pkg::status_t'(err_n);
		end else if (phase_n == adts_pkg::PH_PAYLOAD || phase_n == adts_pkg::PH_SKIP) begin
			fin_status = adts_pkg::ST_TRUNC;
		end else if (!any_n) begin
			fin_status = adts_pkg::ST_EMPTY;
		end else begin
			fin_status = adts_pkg::ST_OK;
		end
	end

	// Order the results: sample first, then status
	always_comb begin
		sample_res.sample    = $signed({data_byte, low_q});
		sample_res.is_status = 1'b0;
		sample_res.status    = adts_pkg::ST_OK;
		sample_res.last      = 1'b0;
		status_res.sample    = 16'sd0;
		status_res.is_status = 1'b1;
		status_res.status    = fin_status;
		status_res.last      = 1'b1;
		results.first  = emit_sample ? sample_res : status_res;
		results.second = status_res;
		results.count  = valid ? (2'(emit_sample) + 2'(last_byte)) : 2'd0;
	end

	// Hold the frame state; the final byte returns it to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= adts_pkg::PH_HEADER;
			hcount_q  <= 3'd0;
			left_q    <= 13'd0;
			lowpend_q <= 1'b0;
			err_q     <= 3'd0;
			any_q     <= 1'b0;
		end else if (valid) begin
			if (last_byte) begin
				phase_q   <= adts_pkg::PH_HEADER;
				hcount_q  <= 3'd0;
				left_q    <= 13'd0;
				lowpend_q <= 1'b0;
				err_q     <= 3'd0;
				any_q     <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				hcount_q  <= hcount_n;
				left_q    <= left_n;
				lowpend_q <= lowpend_n;
				err_q     <= err_n;
				any_q     <= any_n;
			end
		end
	end

	// Header bytes and held low byte
	always_ff @(posedge clk) begin
		if (valid) begin
			hdr0_q <= hdr0_n;
			sync_q <= sync_n;
			hdr_q  <= hdr_n;
			low_q  <= low_n;
		end
	end

endmodule

### rtl/adts_fifo.sv
// ----------------------------------------------------------------------------
// adts_fifo: result queue
// Takes up to two results a cycle and presents one at its head; flags when
// there is room for the results of two more bytes. DEPTH is a power of two.
// ----------------------------------------------------------------------------
module adts_fifo #(
	parameter int unsigned DEPTH = adts_pkg::FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  adts_pkg::res_pair_t  push,
	adts_result_if.source        result_stream,
	output logic                 room
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	adts_pkg::res_t mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  count_q;
	logic           pop;

	assign pop  = result_stream.valid && result_stream.ready;
	assign room = count_q <= CW'(DEPTH - 4);

	// Present the head entry
	assign result_stream.valid     = count_q != '0;
	assign result_stream.sample    = mem_q[rd_q].sample;
	assign result_stream.is_status = mem_q[rd_q].is_status;
	assign result_stream.status    = mem_q[rd_q].status;
	assign result_stream.last      = mem_q[rd_q].last;

	// Write up to two entries
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + PW'(1)] <= push.second;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PW'(push.count);
			rd_q    <= rd_q + PW'(pop);
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

endmodule

### rtl/adts_pcm_frame_deframer.sv
// ----------------------------------------------------------------------------
// adts_pcm_frame_deframer: ADTS-framed PCM deframer
// Parses 7-byte ADTS headers and turns payload byte pairs into Q1.15 samples.
// ----------------------------------------------------------------------------
// Usage:
//   byte_stream takes one buffer byte per transfer; last_byte marks the final
//   byte. result_stream delivers little-endian signed samples as they complete,
//   then one status result (is_status = 1, last = 1) after the final byte.
//   Samples are speculative: drop those of a buffer whose status is not ok.
// Timing: a byte is registered, parsed in the next cycle and its results
//   are written to the result queue, which registers them and presents
//   the oldest one at its head.
// Throughput: one byte per cycle while the queue has room. A final byte that
//   completes a sample yields two results, which the single-result output drains one after the other.
// Reset: arst_n clears the parser to header collection and empties the queue.
// Stall: when result_stream.ready is low, results wait in the queue;
//   byte_stream.ready drops once the queue can no longer absorb two bytes.
// ----------------------------------------------------------------------------
module adts_pcm_frame_deframer #(
	parameter int unsigned FIFO_DEPTH = adts_pkg::FIFO_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	adts_byte_if.sink     byte_stream,
	adts_result_if.source result_stream
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                room;
	adts_pkg::res_pair_t results;

	assign byte_stream.ready = room;

	// Register the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= byte_stream.valid && byte_stream.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			byte_s1 <= byte_stream.data_byte;
			last_s1 <= byte_stream.last_byte;
		end
	end

	adts_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_s1),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.results   (results)
	);

	adts_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (results),
		.result_stream (result_stream),
		.room          (room)
	);

endmodule

### tb/sv/adts_pcm_frame_deframer_checker.sv
// ----------------------------------------------------------------------------
// adts_pcm_frame_deframer_checker: result predictor and scoreboard
// Watches both channels of the deframer. Every byte transfer runs through a
// behavioral parser that tracks header, payload and error state and queues the
// samples and end status that byte should produce. Every result transfer is
// compared field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module adts_pcm_frame_deframer_checker (
	input  logic        clk,
	input  logic        arst_n,
	adts_byte_if        byte_mon,
	adts_result_if      result_mon,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	localparam logic [2:0]  LAST_HDR_IDX = 3'(adts_pkg::HDR_BYTES - 1);
	localparam logic [12:0] HDR_LEN      = 13'(adts_pkg::HDR_BYTES);

	// Parser state
	adts_pkg::phase_t  ph;
	logic [2:0]        hdr_count;
	logic [7:0]        hdr_store [4];
	logic [12:0]       pay_left;
	logic [7:0]        low_half;
	logic              low_pending;
	adts_pkg::status_t err_code;
	logic              any_sample;

	adts_pkg::res_t due_results [$];
	int unsigned    fail_count = 0;
	int unsigned    queued = 0;

	assign mismatches  = fail_count;
	assign outstanding = queued;

	task automatic queue_result(input adts_pkg::res_t r);
		due_results.insert(due_results.size(), r);
	endtask

	task automatic clear_parser();
		ph          = adts_pkg::PH_HEADER;
		hdr_count   = '0;
		pay_left    = '0;
		low_pending = 1'b0;
		err_code    = adts_pkg::ST_OK;
		any_sample  = 1'b0;
	endtask

	task automatic commit_error(input adts_pkg::status_t code);
		err_code = code;
		ph       = adts_pkg::PH_ERROR;
	endtask

	task automatic take_header_byte(input logic [7:0] b);
		logic [12:0] frame_len;
		logic [12:0] pay;
		// Keep byte 0, then fold it into the sync verdict; keep the length bytes
		case (hdr_count)
			3'd0: begin
				hdr_store[0] = b;
			end
			3'd1: begin
				hdr_store[0] = (hdr_store[0] == adts_pkg::SYNC_BYTE &&
					b[7:4] == adts_pkg::SYNC_NIBBLE) ? 8'd1 : 8'd0;
			end
			3'd3, 3'd4, 3'd5: begin
				hdr_store[2'(hdr_count - 3'd2)] = b;
			end
			default: ;
		endcase
		if (hdr_count == LAST_HDR_IDX) begin
			// Header complete: check sync and length, then enter any payload
			hdr_count = '0;
			frame_len = {hdr_store[1][1:0], hdr_store[2], hdr_store[3][7:5]};
			if (hdr_store[0] != 8'd1) begin
				commit_error(adts_pkg::ST_SYNC);
			end else if (frame_len < HDR_LEN) begin
				commit_error(adts_pkg::ST_SHORT);
			end else if (frame_len != HDR_LEN) begin
				pay         = frame_len - HDR_LEN;
				pay_left    = pay;
				low_pending = 1'b0;
				ph          = pay[0] ? adts_pkg::PH_SKIP : adts_pkg::PH_PAYLOAD;
			end
		end else begin
			hdr_count = hdr_count + 3'd1;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic fin);
		adts_pkg::res_t r;
		case (ph)
			adts_pkg::PH_HEADER: begin
				take_header_byte(b);
			end
			adts_pkg::PH_PAYLOAD: begin
				// Hold the low byte, emit a sample on the high byte
				if (!low_pending) begin
					low_half    = b;
					low_pending = 1'b1;
				end else begin
					r.sample    = {b, low_half};
					r.is_status = 1'b0;
					r.status    = adts_pkg::ST_OK;
					r.last      = 1'b0;
					queue_result(r);
					low_pending = 1'b0;
					any_sample  = 1'b1;
				end
				pay_left = pay_left - 13'd1;
				if (pay_left == '0) begin
					ph        = adts_pkg::PH_HEADER;
					hdr_count = '0;
				end
			end
			adts_pkg::PH_SKIP: begin
				pay_left = pay_left - 13'd1;
				if (pay_left == '0)
					commit_error(adts_pkg::ST_ODD);
			end
			default: ;
		endcase

		// Close the buffer with one status and start over
		if (fin) begin
			r.sample    = '0;
			r.is_status = 1'b1;
			r.last      = 1'b1;
			if (err_code != adts_pkg::ST_OK)
				r.status = err_code;
			else if (ph == adts_pkg::PH_PAYLOAD || ph == adts_pkg::PH_SKIP)
				r.status = adts_pkg::ST_TRUNC;
			else if (!any_sample)
				r.status = adts_pkg::ST_EMPTY;
			else
				r.status = adts_pkg::ST_OK;
			queue_result(r);
			clear_parser();
		end
	endtask

	initial clear_parser();

	// Predict on byte transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin : watch
		adts_pkg::res_t got;
		adts_pkg::res_t want;
		if (!arst_n) begin
			clear_parser();
			due_results.delete();
		end else begin
			if (byte_mon.valid && byte_mon.ready)
				parse_byte(byte_mon.data_byte, byte_mon.last_byte);
			if (result_mon.valid && result_mon.ready) begin
				got.sample    = result_mon.sample;
				got.is_status = result_mon.is_status;
				got.status    = result_mon.status;
				got.last      = result_mon.last;
				if (due_results.size() == 0) begin
					fail_count++;
					$display({"%0t: unexpected result: expected none, ",
						"got sample %0d is_status %0b status %0d last %0b"},
						$time, got.sample, got.is_status, got.status, got.last);
				end else begin
					want = due_results.pop_front();
					if (got.sample !== want.sample || got.is_status !== want.is_status ||
						got.status !== want.status || got.last !== want.last) begin
						fail_count++;
						$display({"%0t: result mismatch: expected sample %0d ",
							"is_status %0b status %0d last %0b"},
							$time, want.sample, want.is_status, want.status, want.last);
						$display({"%0t:                  got      sample %0d ",
							"is_status %0b status %0d last %0b"},
							$time, got.sample, got.is_status, got.status, got.last);
					end
				end
			end
		end
		queued = due_results.size();
	end

endmodule

### tb/sv/adts_pcm_frame_deframer_test.sv
// ----------------------------------------------------------------------------
// adts_pcm_frame_deframer_test: top-level testbench for the ADTS deframer
// Sends a few directed buffers (empty, bad sync, short length, good samples at
// the Q1.15 extremes), then random buffers built mostly from well-formed frames
// with random content, plus odd, short, bad-sync, truncated and noise buffers.
// Both sides stall at random; the checker module predicts and compares.
// ----------------------------------------------------------------------------
module adts_pcm_frame_deframer_test;

	localparam int unsigned RANDOM_BYTES = 1150;
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned DRAIN_CYCLES = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned mismatches;
	int unsigned outstanding;
	logic        send_calm = 1'b0;
	logic        take_calm = 1'b0;
	logic [7:0]  buffer_bytes [$];

	adts_byte_if   byte_stream ();
	adts_result_if result_stream ();

	adts_pcm_frame_deframer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_stream   (byte_stream),
		.result_stream (result_stream)
	);

	adts_pcm_frame_deframer_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_mon    (byte_stream),
		.result_mon  (result_stream),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("adts_pcm_frame_deframer verification failed");
			$finish;
		end
	end

	// Accept results with random stalls, in bursts of none
	initial begin : take_results
		int unsigned stall;
		result_stream.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0)
				take_calm = !take_calm;
			stall = take_calm ? 0 : $urandom_range(0, 13);
			if (stall != 0) begin
				result_stream.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_stream.ready <= 1'b1;
			do @(posedge clk); while (!result_stream.valid);
		end
	end

	task automatic append_byte(input logic [7:0] b);
		buffer_bytes.insert(buffer_bytes.size(), b);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int unsigned gap;
		if ($urandom_range(0, 63) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			byte_stream.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_stream.valid     <= 1'b1;
		byte_stream.data_byte <= b;
		byte_stream.last_byte <= fin;
		do @(posedge clk); while (!byte_stream.ready);
		bytes_sent++;
	endtask

	task automatic send_buffer();
		foreach (buffer_bytes[i])
			send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
	endtask

	task automatic add_header(input logic [12:0] frame_len, input logic good_sync);
		logic [7:0] h0;
		logic [7:0] h1;
		h0 = adts_pkg::SYNC_BYTE;
		h1 = {adts_pkg::SYNC_NIBBLE, 4'($urandom_range(0, 15))};
		// Break either sync byte or the sync nibble
		if (!good_sync) begin
			if ($urandom_range(0, 1))
				h0 = 8'($urandom_range(0, 254));
			else
				h1[7:4] = 4'($urandom_range(0, 14));
		end
		append_byte(h0);
		append_byte(h1);
		append_byte(8'($urandom));
		append_byte({6'($urandom), frame_len[12:11]});
		append_byte(frame_len[10:3]);
		append_byte({frame_len[2:0], 5'($urandom)});
		append_byte(8'($urandom));
	endtask

	task automatic add_payload(input int unsigned n);
		repeat (n) append_byte(8'($urandom));
	endtask

	// Build one buffer: mostly good frames, some broken ones, some noise
	task automatic build_buffer();
		int unsigned frames;
		int unsigned kind;
		int unsigned pay;
		logic        stop;
		buffer_bytes.delete();
		stop = 1'b0;
		if ($urandom_range(0, 19) == 0) begin
			add_payload($urandom_range(1, 20));
		end else begin
			frames = $urandom_range(0, 3);
			for (int f = 0; f < frames && !stop; f++) begin
				kind = $urandom_range(0, 99);
				if (kind < 60) begin
					pay = 2 * $urandom_range(0, 12);
					add_header(13'(pay + adts_pkg::HDR_BYTES), 1'b1);
					add_payload(pay);
				end else if (kind < 70) begin
					pay = 2 * $urandom_range(0, 8) + 1;
					add_header(13'(pay + adts_pkg::HDR_BYTES), 1'b1);
					add_payload(pay);
				end else if (kind < 78) begin
					add_header(13'($urandom_range(0, adts_pkg::HDR_BYTES - 1)), 1'b1);
				end else if (kind < 85) begin
					add_header(13'($urandom), 1'b0);
					add_payload($urandom_range(0, 6));
				end else if (kind < 95) begin
					// Frame runs past the end of the buffer
					pay = $urandom_range(1, 40);
					add_header(13'(pay + adts_pkg::HDR_BYTES), 1'b1);
					add_payload($urandom_range(0, pay - 1));
					stop = 1'b1;
				end else begin
					add_header(13'($urandom_range(64, 8191)), 1'b1);
					add_payload($urandom_range(0, 12));
					stop = 1'b1;
				end
			end
			// Trail off with part of a header
			if (!stop && $urandom_range(0, 4) == 0) begin
				append_byte($urandom_range(0, 1) ? adts_pkg::SYNC_BYTE : 8'($urandom));
				add_payload($urandom_range(0, 5));
			end
		end
		if (buffer_bytes.size() == 0)
			append_byte(8'($urandom));
	endtask

	initial begin : make_stimulus
		int unsigned directed_bytes;
		byte_stream.valid     = 1'b0;
		byte_stream.data_byte = '0;
		byte_stream.last_byte = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lone partial header: empty buffer
		buffer_bytes = '{8'hFF};
		send_buffer();
		// Bad sync nibble
		buffer_bytes = '{8'hFF, 8'hE1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_buffer();
		// Frame length of six
		buffer_bytes = '{8'hFF, 8'hF1, 8'h50, 8'h80, 8'h00, 8'hC0, 8'hFC};
		send_buffer();
		// Good frame with full-scale positive and negative samples
		buffer_bytes = '{8'hFF, 8'hF1, 8'h50, 8'h80, 8'h01, 8'h7F, 8'hFC,
			8'hFF, 8'h7F, 8'h00, 8'h80};
		send_buffer();
		directed_bytes = bytes_sent;

		while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
			build_buffer();
			send_buffer();
		end
		byte_stream.valid <= 1'b0;

		// Drain outstanding results, then let the pipeline settle
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("adts_pcm_frame_deframer verification clean");
		else
			$display("adts_pcm_frame_deframer verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/adts_pkg.sv
rtl/adts_byte_if.sv
rtl/adts_result_if.sv
rtl/adts_parse.sv
rtl/adts_fifo.sv
rtl/adts_pcm_frame_deframer.sv
tb/sv/adts_pcm_frame_deframer_checker.sv
tb/sv/adts_pcm_frame_deframer_test.sv
